@@ hdl/slst_pkg.sv @@
package slst_pkg;

  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned POS_W        = 6;
  localparam int unsigned CAPACITY_DEF = 16;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_STREAM = 2'b10
  } back_state_e;

  // one queued insert request, front to back
  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] value;
  } slst_item_t;

endpackage

@@ hdl/slst_if.sv @@
interface slst_in_if import slst_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] new_value;

  modport source (output valid, output new_value, input ready);
  modport sink   (input valid, input new_value, output ready);
endinterface

interface slst_out_if import slst_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] entry_value;
  logic        [POS_W-1:0]   entry_position;
  logic                      last_entry;
  logic                      overflow;

  modport source (output valid, output entry_value, output entry_position,
                  output last_entry, output overflow, input ready);
  modport sink   (input valid, input entry_value, input entry_position,
                  input last_entry, input overflow, output ready);
endinterface

@@ hdl/slst_front.sv @@
module slst_front import slst_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic signed [VALUE_W-1:0] in_value_i,
  output logic                      in_ready_o,
  output slst_item_t                item_o,
  input  logic                      pop_i
);

  // two-entry queue decoupling the input from the insert/readout engine
  logic signed [VALUE_W-1:0] mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push, pop;

  assign in_ready_o = (fill_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (fill_q != 2'd0);

  assign item_o.valid = (fill_q != 2'd0);
  assign item_o.value = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

@@ hdl/slst_back.sv @@
module slst_back import slst_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  slst_item_t                item_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [VALUE_W-1:0] entry_value_o,
  output logic        [POS_W-1:0]   entry_position_o,
  output logic                      last_entry_o,
  output logic                      overflow_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic signed [VALUE_W-1:0] store_q  [CAPACITY];
  logic signed [VALUE_W-1:0] store_d  [CAPACITY];
  logic signed [VALUE_W-1:0] shadow_q [CAPACITY];
  logic [CAPACITY-1:0]       lt;
  logic [CW-1:0]             count_q;
  logic [CW-1:0]             len_q;
  logic [CW-1:0]             pos_q;
  logic                      ovf_q;
  logic                      full;
  logic                      is_last;
  logic                      xfer;
  back_state_e               state_q, state_d;

  assign full = (count_q == CW'(CAPACITY));

  // each cell compares itself with the new value; cells below count are sorted,
  // so lt is a run of ones from the bottom up to the insert point
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt[i] = (CW'(i) < count_q) && (store_q[i] < item_i.value);
    end
    store_d[0] = lt[0] ? store_q[0] : item_i.value;
    for (int i = 1; i < CAPACITY; i++) begin
      if (lt[i]) begin
        store_d[i] = store_q[i];
      end else if (lt[i-1]) begin
        store_d[i] = item_i.value;
      end else begin
        store_d[i] = store_q[i-1];
      end
    end
  end

  assign pop_o   = (state_q == ST_IDLE) && item_i.valid;
  assign is_last = (pos_q == len_q - CW'(1));
  assign xfer    = out_valid_o && out_ready_i;

  assign out_valid_o      = (state_q == ST_STREAM);
  assign entry_value_o    = shadow_q[0];
  assign entry_position_o = POS_W'(pos_q);
  assign last_entry_o     = is_last;
  assign overflow_o       = ovf_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_i.valid) begin
          state_d = ST_STREAM;
        end
      end
      ST_STREAM: begin
        if (xfer && is_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // store and readout copy: payload only
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (!full) begin
          store_q[i] <= store_d[i];
        end
        shadow_q[i] <= full ? store_q[i] : store_d[i];
      end
      ovf_q <= full;
    end else if (xfer) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        shadow_q[i] <= shadow_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      len_q   <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        pos_q <= '0;
        if (full) begin
          len_q <= count_q;
        end else begin
          len_q   <= count_q + CW'(1);
          count_q <= count_q + CW'(1);
        end
      end else if (xfer) begin
        pos_q <= pos_q + CW'(1);
      end
    end
  end

endmodule

@@ hdl/sorted_list_insert_core.sv @@
// Channel  Dir  Payload                                             Transfer
// in_i     in   new_value[31:0] signed                              valid && ready
// out_o    out  entry_value[31:0], entry_position[5:0],             valid && ready
//               last_entry, overflow
//
// Each insert is applied in the back engine's idle state, then the list is streamed
// one entry per cycle while the output is ready: n entries, n = list length (up to CAPACITY).
// The back engine takes no new item until the readout of the list copy ends.
// A two-entry queue lets up to two inputs be taken while a listing streams.
// Reset (rst_ni low, async) empties the list and the queue; stored values
// need no reset. A stalled output holds its entry; the queue fills behind it.
module sorted_list_insert_core import slst_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  slst_in_if.sink           in_i,
  slst_out_if.source        out_o
);

  slst_item_t item;
  logic       pop;

  slst_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_value_i (in_i.new_value),
    .in_ready_o (in_i.ready),
    .item_o     (item),
    .pop_i      (pop)
  );

  slst_back #(.CAPACITY(CAPACITY)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (item),
    .pop_o            (pop),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .entry_value_o    (out_o.entry_value),
    .entry_position_o (out_o.entry_position),
    .last_entry_o     (out_o.last_entry),
    .overflow_o       (out_o.overflow)
  );

endmodule

@@ hdl/slst_checker.sv @@
module slst_checker import slst_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [POS_W-1:0] entry_position_i,
  input logic             last_entry_i,
  input logic             overflow_i
);

  logic mid_xfer;
  assign mid_xfer = out_valid_i && out_ready_i && !last_entry_i;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output dropped valid while stalled");

  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_xfer |=> out_valid_i)
    else $error("gap inside a listing");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_xfer |=> entry_position_i == POS_W'($past(entry_position_i) + 1'b1))
    else $error("entry position did not advance by one");

  a_ovf_const: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_xfer |=> overflow_i == $past(overflow_i))
    else $error("overflow flag changed inside a listing");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && overflow_i && last_entry_i |->
      entry_position_i == POS_W'(CAPACITY - 1))
    else $error("overflow listing is not a full list");

endmodule

bind sorted_list_insert_core slst_checker #(.CAPACITY(CAPACITY)) u_slst_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .entry_position_i (out_o.entry_position),
  .last_entry_i     (out_o.last_entry),
  .overflow_i       (out_o.overflow)
);
